/* rtl/core/pftlc_pkg.sv */
// shared types, codes and constants of the pump-time fluid level controller
// no dependencies; imported by the state store, the divider and the top level
package pftlc_pkg;
   localparam int NUM_POTS = 4;
   localparam int POT_W    = 2;
   localparam int EST_W    = 32;
   localparam int FIELD_W  = 25;
   localparam int CFG_W    = 24;
   localparam int DVD_W    = 39;
   localparam int DVS_W    = 32;
   localparam int CNT_W    = 6;

   localparam logic [CFG_W-1:0] MAX24     = 24'hFFFFFF;
   localparam logic [CFG_W-1:0] RST_EXTRA = 24'd10000;
   localparam logic [6:0]       LVL_FULL  = 7'd100;

   // ceil(2^38 / 100): exact quotient by 100 for dividends below 2^31
   localparam logic [31:0]      RECIP_100 = 32'd2748779070;
   localparam int               RECIP_SH  = 38;

   localparam logic signed [1:0] DIR_FLOOD = 2'sb01;
   localparam logic signed [1:0] DIR_DRAIN = 2'sb11;
   localparam logic signed [1:0] DIR_OFF   = 2'sb00;

   typedef enum logic [1:0] {
      KIND_TICK      = 2'd0,
      KIND_FLUID     = 2'd1,
      KIND_CONTAINER = 2'd2,
      KIND_LEVEL     = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_OVERFLOW = 2'd1,
      ERR_OVERFILL = 2'd2,
      ERR_UNCAL    = 2'd3
   } err_type;

   typedef enum logic [1:0] {
      REG_ENABLE        = 2'd0,
      REG_MAX_CONTAINER = 2'd1,
      REG_EXTRA_DRAIN   = 2'd2,
      REG_EXTRA_FLOOD   = 2'd3
   } reg_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_APPLY, ST_LEVEL, ST_TDIV, ST_DIR,
      ST_TICK, ST_SHOW, ST_LSTART, ST_LDIV, ST_OUT
   } seq_type;

   typedef struct packed {
      logic signed [EST_W-1:0] fluid_est;
      logic signed [EST_W-1:0] container_est;
      logic                    fluid_good;
      logic                    container_good;
      logic signed [EST_W-1:0] fluid_target;
      logic signed [1:0]       prev_dir;
      logic signed [1:0]       pump_cmd;
      logic                    overfill_is_error;
      err_type                 error_state;
   } pot_state_type;

   localparam pot_state_type POT_RESET = '{
      fluid_est:         -32'sd1,
      container_est:     32'sd16777215,
      fluid_good:        1'b0,
      container_good:    1'b0,
      fluid_target:      32'sd0,
      prev_dir:          DIR_OFF,
      pump_cmd:          DIR_OFF,
      overfill_is_error: 1'b0,
      error_state:       ERR_NONE
   };

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   function automatic logic signed [EST_W-1:0] sat32(input logic signed [EST_W:0] v);
      logic signed [EST_W-1:0] r;
      if (v[EST_W] != v[EST_W-1]) begin
         r = v[EST_W] ? {1'b1, {(EST_W-1){1'b0}}} : {1'b0, {(EST_W-1){1'b1}}};
      end else begin
         r = v[EST_W-1:0];
      end
      return r;
   endfunction
endpackage

/* rtl/core/pftlc_state_mem.sv */
// per-pot state store: one write port, one registered read port
// uses pftlc_pkg; entries never written read as the reset state
module pftlc_state_mem (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [pftlc_pkg::POT_W-1:0]   rd_addr,
   output pftlc_pkg::pot_state_type      rd_data,
   input  logic                          wr_en,
   input  logic [pftlc_pkg::POT_W-1:0]   wr_addr,
   input  pftlc_pkg::pot_state_type      wr_data
);
   import pftlc_pkg::*;

   pot_state_type mem [NUM_POTS];
   logic [NUM_POTS-1:0] valid_ff;
   pot_state_type       raw_ff;
   logic                hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         raw_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            hit_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = hit_ff ? raw_ff : POT_RESET;
endmodule

/* rtl/core/pftlc_div.sv */
// restoring divider, one quotient bit per cycle
// uses pftlc_pkg; done pulses as the last quotient bit is registered
module pftlc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  pftlc_pkg::div_req_type        req,
   output logic                          done,
   output logic [pftlc_pkg::DVD_W-1:0]   quotient
);
   import pftlc_pkg::*;

   logic [DVS_W:0]   rem_ff, rem_in, rem_shift;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             run_ff, done_ff;
   logic             ge;

   always_comb begin
      rem_shift = {rem_ff[DVS_W-1:0], quo_ff[DVD_W-1]};
      ge        = rem_shift >= {1'b0, dvs_ff};
      rem_in    = ge ? rem_shift - {1'b0, dvs_ff} : rem_shift;
      quo_in    = {quo_ff[DVD_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= '0;
         quo_ff <= req.dividend;
         dvs_ff <= req.divisor;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DVD_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

/* rtl/core/pump_time_fluid_level_controller.sv */
// channel | dir | fields, lowest bit first
// req     | in  | tuser: kind; tdata: pot_index, tick_ms, overflow_seen, full_seen,
//         |     |        estimate_value, level_target
// rsp     | out | tdata: pump_dir, fluid_shown, container_shown, level_percent, error_code
// csr     | in  | csr_we, csr_index, csr_wdata (24 bits), no read-back
// one request at a time: load, apply, then a tick step or the level, divide-by-100 and
// direction steps as the kind needs, show, level start, the level divide when both
// estimates are good, and out; the next request is taken once the response is loaded
// the 39-step level divider is the longest step; state is read and written back once
// reset is synchronous; all pots start uncalibrated with the pump off
// a finished response waits in the output register while the next request is taken
// uses pftlc_pkg, pftlc_state_mem, pftlc_div
module pump_time_fluid_level_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,  // kind
   input  logic [55:0] req_tdata,  // pot_index, tick_ms, overflow_seen, full_seen,
                                   // estimate_value, level_target, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // pump_dir, fluid_shown, container_shown,
                                   // level_percent, error_code, zero fill
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);
   import pftlc_pkg::*;

   seq_type state_ff, state_in;

   logic              en_ff;
   logic [CFG_W-1:0]  maxc_ff, drain_ff, flood_ff;

   kind_type                   kind_ff;
   logic [POT_W-1:0]           pot_ff;
   logic [15:0]                tick_ff;
   logic                       ovf_ff, full_ff;
   logic signed [FIELD_W-1:0]  est_ff;
   logic [6:0]                 lvl_ff, lvl_in;

   pot_state_type cur_ff, cur_in, rd_data;

   logic signed [EST_W-1:0] fsc_ff, fsc_in;
   logic [FIELD_W-1:0]      fs_show_ff, fs_show_in, cs_show_ff, cs_show_in;
   logic [7:0]              lv_ff, lv_in;

   logic        rsp_valid_ff;
   logic [63:0] rsp_data_ff;

   logic        accept, rd_en, wr_en, load_out;
   div_req_type div_req;
   logic        div_done;
   logic [DVD_W-1:0] div_q;

   logic signed [EST_W:0]   step, sum33, fsum33;
   logic signed [EST_W-1:0] est32, fs_tmp;
   logic                    allowed;
   logic [30:0]             lvl_prod;
   logic [63:0]             tdiv_prod;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign lvl_in     = (req_tdata[51:45] > LVL_FULL) ? LVL_FULL : req_tdata[51:45];
   assign est32      = {{(EST_W-FIELD_W){est_ff[FIELD_W-1]}}, est_ff};

   pftlc_state_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (req_tdata[1:0]),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (pot_ff),
      .wr_data (cur_ff)
   );

   pftlc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         en_ff        <= 1'b0;
         maxc_ff      <= MAX24;
         drain_ff     <= RST_EXTRA;
         flood_ff     <= RST_EXTRA;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (reg_idx_type'(csr_index))
               REG_ENABLE:        en_ff    <= csr_wdata[0];
               REG_MAX_CONTAINER: maxc_ff  <= csr_wdata;
               REG_EXTRA_DRAIN:   drain_ff <= csr_wdata;
               REG_EXTRA_FLOOD:   flood_ff <= csr_wdata;
               default:           en_ff    <= en_ff;
            endcase
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= kind_type'(req_tuser);
         pot_ff  <= req_tdata[1:0];
         tick_ff <= req_tdata[17:2];
         ovf_ff  <= req_tdata[18];
         full_ff <= req_tdata[19];
         est_ff  <= req_tdata[44:20];
         lvl_ff  <= lvl_in;
      end
      cur_ff     <= cur_in;
      fsc_ff     <= fsc_in;
      fs_show_ff <= fs_show_in;
      cs_show_ff <= cs_show_in;
      lv_ff      <= lv_in;
      if (load_out) begin
         rsp_data_ff <= {2'b00, cur_ff.error_state, lv_ff, cs_show_ff, fs_show_ff,
                         cur_ff.pump_cmd};
      end
   end

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      fsc_in     = fsc_ff;
      fs_show_in = fs_show_ff;
      cs_show_in = cs_show_ff;
      lv_in      = lv_ff;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      load_out   = 1'b0;
      div_req    = '{start: 1'b0, dividend: '0, divisor: '0};
      step       = (cur_ff.prev_dir == DIR_FLOOD) ? $signed({17'b0, tick_ff})
                                                  : -$signed({17'b0, tick_ff});
      sum33      = {cur_ff.fluid_est[EST_W-1], cur_ff.fluid_est} + step;
      fsum33     = {cur_ff.container_est[EST_W-1], cur_ff.container_est}
                   + $signed({9'b0, flood_ff});
      allowed    = (lvl_ff == 7'd0) || (lvl_ff == LVL_FULL)
                   || (cur_ff.fluid_good && cur_ff.container_good);
      fs_tmp     = (cur_ff.fluid_est > cur_ff.container_est) ? cur_ff.container_est
                                                             : cur_ff.fluid_est;
      lvl_prod   = cur_ff.container_est[CFG_W-1:0] * lvl_ff;
      tdiv_prod  = cur_ff.fluid_target[30:0] * RECIP_100;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rd_en    = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cur_in   = rd_data;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            state_in = ST_SHOW;
            unique case (kind_ff)
               KIND_TICK: begin
                  if (full_ff && cur_ff.pump_cmd == DIR_FLOOD) cur_in.pump_cmd = DIR_OFF;
                  if (ovf_ff) cur_in.pump_cmd = DIR_OFF;
                  if (en_ff) begin
                     if (cur_ff.prev_dir != DIR_OFF) cur_in.fluid_est = sat32(sum33);
                     state_in = ST_TICK;
                  end
               end
               KIND_FLUID: begin
                  if (est_ff < 0) begin
                     cur_in.fluid_est  = -32'sd1;
                     cur_in.fluid_good = 1'b0;
                  end else if (cur_ff.container_good && est32 <= cur_ff.container_est) begin
                     cur_in.fluid_est  = est32;
                     cur_in.fluid_good = 1'b1;
                  end
               end
               KIND_CONTAINER: begin
                  if (est_ff < 0) begin
                     cur_in.container_est  = $signed({8'b0, maxc_ff});
                     cur_in.container_good = 1'b0;
                  end else begin
                     cur_in.container_est  = est32;
                     cur_in.container_good = 1'b1;
                  end
               end
               KIND_LEVEL: begin
                  if (!allowed) begin
                     cur_in.error_state = ERR_UNCAL;
                  end else begin
                     if (!cur_ff.fluid_good) begin
                        cur_in.fluid_est = (lvl_ff == 7'd0) ? cur_ff.container_est : '0;
                     end else begin
                        if ($unsigned(cur_ff.container_est) > {8'b0, maxc_ff})
                           cur_in.container_est = $signed({8'b0, maxc_ff});
                        if (cur_ff.fluid_est < 0) cur_in.fluid_est = '0;
                     end
                     state_in = ST_LEVEL;
                  end
               end
               default: state_in = ST_SHOW;
            endcase
         end
         ST_LEVEL: begin
            if (cur_ff.fluid_good && cur_ff.fluid_est > cur_ff.container_est)
               cur_in.fluid_est = cur_ff.container_est;
            cur_in.overfill_is_error = 1'b0;
            state_in = ST_DIR;
            if (lvl_ff == 7'd0) begin
               cur_in.fluid_target = 32'sd0 - $signed({8'b0, drain_ff});
            end else if (lvl_ff == LVL_FULL) begin
               cur_in.fluid_target      = sat32(fsum33);
               cur_in.overfill_is_error = 1'b1;
            end else begin
               // container was clamped to 24 bits in ST_APPLY; product held in the target
               cur_in.fluid_target = $signed({1'b0, lvl_prod});
               state_in            = ST_TDIV;
            end
         end
         ST_TDIV: begin
            // divide by 100 through the reciprocal
            cur_in.fluid_target = $signed({6'b0, tdiv_prod[63:RECIP_SH]});
            state_in            = ST_DIR;
         end
         ST_DIR: begin
            cur_in.error_state = ERR_NONE;
            if (cur_ff.fluid_target > cur_ff.fluid_est)      cur_in.pump_cmd = DIR_FLOOD;
            else if (cur_ff.fluid_target < cur_ff.fluid_est) cur_in.pump_cmd = DIR_DRAIN;
            else                                             cur_in.pump_cmd = DIR_OFF;
            cur_in.prev_dir = cur_in.pump_cmd;
            state_in        = ST_SHOW;
         end
         ST_TICK: begin
            if (cur_ff.prev_dir != DIR_OFF && cur_ff.fluid_est > cur_ff.container_est)
               cur_in.container_est = cur_ff.fluid_est;
            priority if (ovf_ff) begin
               cur_in.fluid_good     = 1'b0;
               cur_in.container_good = 1'b0;
               cur_in.container_est  = $signed({8'b0, maxc_ff});
               cur_in.error_state    = ERR_OVERFLOW;
            end else if (cur_ff.prev_dir == DIR_FLOOD
                         && cur_ff.fluid_est >= cur_ff.fluid_target) begin
               if (cur_ff.overfill_is_error) begin
                  cur_in.fluid_good     = 1'b0;
                  cur_in.container_good = 1'b0;
                  cur_in.container_est  = $signed({8'b0, maxc_ff});
                  cur_in.error_state    = ERR_OVERFILL;
               end
               cur_in.pump_cmd = DIR_OFF;
            end else if (cur_ff.prev_dir == DIR_DRAIN
                         && cur_ff.fluid_est <= cur_ff.fluid_target) begin
               if (cur_ff.fluid_target < 0) cur_in.fluid_good = 1'b1;
               cur_in.pump_cmd = DIR_OFF;
            end else if (cur_ff.prev_dir == DIR_FLOOD && full_ff) begin
               if (cur_ff.fluid_good) begin
                  cur_in.container_est  = cur_ff.fluid_est;
                  cur_in.container_good = 1'b1;
               end
               cur_in.pump_cmd = DIR_OFF;
            end else begin
               cur_in.pump_cmd = cur_ff.pump_cmd;
            end
            cur_in.prev_dir = cur_in.pump_cmd;
            state_in        = ST_SHOW;
         end
         ST_SHOW: begin
            wr_en  = 1'b1;
            fsc_in = (fs_tmp < 0) ? '0 : fs_tmp;
            if (!cur_ff.fluid_good) begin
               fs_show_in = '1;
            end else if (fs_tmp < 0) begin
               fs_show_in = '0;
            end else if (fs_tmp > $signed({8'b0, MAX24})) begin
               fs_show_in = {1'b0, MAX24};
            end else begin
               fs_show_in = fs_tmp[FIELD_W-1:0];
            end
            if (!cur_ff.container_good) begin
               cs_show_in = '1;
            end else if (cur_ff.container_est < 0) begin
               cs_show_in = '0;
            end else if (cur_ff.container_est > $signed({8'b0, MAX24})) begin
               cs_show_in = {1'b0, MAX24};
            end else begin
               cs_show_in = cur_ff.container_est[FIELD_W-1:0];
            end
            state_in = ST_LSTART;
         end
         ST_LSTART: begin
            state_in = ST_OUT;
            if (!(cur_ff.fluid_good && cur_ff.container_good)) begin
               lv_in = '1;
            end else if (cur_ff.container_est <= 0) begin
               lv_in = '0;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = DVD_W'({7'b0, fsc_ff} * {{(DVD_W-7){1'b0}}, LVL_FULL});
               div_req.divisor  = cur_ff.container_est;
               state_in         = ST_LDIV;
            end
         end
         ST_LDIV: begin
            if (div_done) begin
               lv_in    = div_q[7:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule

/* rtl/core/pftlc_checker.sv */
// port-level checks of the pump-time fluid level controller
// no package needed; bound to the top level below
module pftlc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");

   // one request in flight
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in work");

   a_dir_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'b10)
      else $error("bad pump direction");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[59:52] == 8'hFF || rsp_tdata[59:52] <= 8'd100))
      else $error("level out of range");

   // a known level needs a known fluid estimate
   a_level_fluid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[59:52] != 8'hFF |-> rsp_tdata[26] == 1'b0)
      else $error("level shown with unknown fluid");
endmodule

bind pump_time_fluid_level_controller pftlc_checker u_pftlc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
